@@ rtl/ztc_pkg.sv @@
// Package: shared types, register codes, datapath commands and controller states.
`default_nettype none
package ztc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int FACE_STEPS    = 11; // multiplies of the facing test per vertex
	localparam int PT_STEPS      = 3;  // multiplies per interpolated point
	localparam int STEP_W        = 4;

	localparam logic signed [31:0] DERIV_THR_RST = 32'sd65536;
	localparam logic [15:0]        COS_SQ_RST    = 16'd65372;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DERIV_THR = 3'd0,
		REG_COS_SQ    = 3'd1,
		REG_DRAW_SUGG = 3'd2,
		REG_BYPASS    = 3'd3,
		REG_DRAW_ZDER = 3'd4
	} ztc_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] radial_curv;
		logic signed [31:0] radial_deriv;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] view_x;
		logic signed [31:0] view_y;
		logic signed [31:0] view_z;
	} ztc_vtx_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic               contour_kind;
		logic               last_of_face;
	} ztc_seg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] curv;
		logic signed [31:0] deriv;
	} ztc_hv_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_FMUL,
		OP_FDONE,
		OP_SEL,
		OP_DINIT,
		OP_DSTEP,
		OP_PMUL
	} ztc_op_t;

	typedef struct packed {
		ztc_op_t           op;
		logic [STEP_W-1:0] step;
		logic              kind;
		logic              edge_sel;
	} ztc_cmd_t;

	typedef struct packed {
		logic       third;
		logic [1:0] seg_live;
	} ztc_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FMUL,
		ST_FDRAIN,
		ST_FDONE,
		ST_SEL,
		ST_DINIT,
		ST_DIV,
		ST_PMUL,
		ST_PDRAIN,
		ST_EMIT0,
		ST_EMIT1
	} ztc_state_t;

endpackage
`default_nettype wire

@@ rtl/ztc_ifs.sv @@
// Interfaces: vertex input, segment output and configuration write channels.
`default_nettype none
interface ztc_vtx_if;
	logic             valid;
	logic             ready;
	ztc_pkg::ztc_vtx_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ztc_seg_if;
	logic             valid;
	logic             ready;
	ztc_pkg::ztc_seg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ztc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ztc_pkg::CFG_IDX_W-1:0]      index;
	logic [ztc_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/triangle_zero_crossing_contour.sv @@
// Top level: zero-crossing contour segment extractor, one triangle at a time.
//
//  channel | dir | payload                         | beat accepted when
//  --------+-----+---------------------------------+-------------------------
//  vtx     | in  | one vertex (position, curv,...) | vtx.valid && vtx.ready
//  seg     | out | one segment, kind, last flag    | seg.valid && seg.ready
//  cfg     | in  | register index and write data   | cfg.valid && cfg.ready
//
// Each vertex runs through accept, 11 issues of the shared 33x33 multiplier for
// the facing test, a drain state and an update state.
// The third vertex of a face then runs, per contour kind, a selection and per
// edge a division by the restoring divider, one quotient bit per cycle, and an
// interpolation; each of the two emit slots is held while the sink stalls.
// vtx.ready is high only while idle; result beats hold until taken.
// Reset clears the vertex slot, facing flag and registers to their defaults.
`default_nettype none
module triangle_zero_crossing_contour #(
	parameter int FRACTION_BITS = ztc_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ztc_vtx_if.sink  vtx,
	ztc_seg_if.source seg,
	ztc_cfg_if.sink  cfg
);
	import ztc_pkg::*;

	ztc_cmd_t cmd;
	ztc_sts_t sts;

	// controller: owns sequencing and both handshakes
	ztc_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx.valid),
		.in_ready  (vtx.ready),
		.out_valid (seg.valid),
		.out_ready (seg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: hold vertices, run the multiplier and divider, store segments
	ztc_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.vtx_data (vtx.data),
		.seg_data (seg.data),
		.cfg      (cfg)
	);

	// never take a vertex while a segment beat is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vtx.ready && seg.valid))
		else $error("vertex accepted while a segment is pending");

	// the face is finished after its last beat
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready && seg.data.last_of_face |=> !seg.valid)
		else $error("segment beat after last_of_face");

	// a derivative segment always closes its face
	a_kind1_last: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.data.contour_kind |-> seg.data.last_of_face)
		else $error("derivative segment not marked last");
endmodule
`default_nettype wire

@@ rtl/ztc_ctrl.sv @@
// Controller: sequences facing multiplies, divisions, interpolation and emission.
`default_nettype none
module ztc_ctrl #(
	parameter int FRACTION_BITS = ztc_pkg::FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ztc_pkg::ztc_sts_t sts,
	output ztc_pkg::ztc_cmd_t      cmd
);
	import ztc_pkg::*;

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);

	ztc_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             kind_q, kind_d;
	logic             edge_q, edge_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			kind_q  <= 1'b0;
			edge_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
			edge_q  <= edge_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		kind_d       = kind_q;
		edge_d       = edge_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd.op       = OP_NONE;
		cmd.step     = cnt_q[STEP_W-1:0];
		cmd.kind     = kind_q;
		cmd.edge_sel = edge_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					cnt_d   = '0;
					state_d = ST_FMUL;
				end
			end
			ST_FMUL: begin
				cmd.op = OP_FMUL;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FACE_STEPS - 1)) begin
					state_d = ST_FDRAIN;
				end
			end
			ST_FDRAIN: begin
				state_d = ST_FDONE;
			end
			ST_FDONE: begin
				cmd.op = OP_FDONE;
				kind_d = 1'b0;
				state_d = sts.third ? ST_SEL : ST_IDLE;
			end
			ST_SEL: begin
				cmd.op  = OP_SEL;
				edge_d  = 1'b0;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op  = OP_DINIT;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DSTEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRACTION_BITS)) begin
					cnt_d   = '0;
					state_d = ST_PMUL;
				end
			end
			ST_PMUL: begin
				cmd.op = OP_PMUL;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PT_STEPS - 1)) begin
					state_d = ST_PDRAIN;
				end
			end
			ST_PDRAIN: begin
				if (!edge_q) begin
					edge_d  = 1'b1;
					state_d = ST_DINIT;
				end else if (!kind_q) begin
					kind_d  = 1'b1;
					state_d = ST_SEL;
				end else begin
					state_d = ST_EMIT0;
				end
			end
			ST_EMIT0: begin
				cmd.kind = 1'b0;
				if (!sts.seg_live[0]) begin
					state_d = ST_EMIT1;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						state_d = ST_EMIT1;
					end
				end
			end
			ST_EMIT1: begin
				cmd.kind = 1'b1;
				if (!sts.seg_live[1]) begin
					state_d = ST_IDLE;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/ztc_datapath.sv @@
// Datapath: config registers, vertex store, shared multiplier, divider, segment store.
`default_nettype none
module ztc_datapath #(
	parameter int FRACTION_BITS = ztc_pkg::FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ztc_pkg::ztc_cmd_t cmd,
	output ztc_pkg::ztc_sts_t      sts,
	input  wire ztc_pkg::ztc_vtx_t vtx_data,
	output ztc_pkg::ztc_seg_t      seg_data,
	ztc_cfg_if.sink                cfg
);
	import ztc_pkg::*;

	localparam int QW  = FRACTION_BITS + 1;
	localparam int DW  = 50;
	localparam int LW  = 64;
	localparam int WW  = 100;
	localparam int MW  = 33;
	localparam int PW  = 66;

	// configuration
	logic signed [31:0] thr_q;
	logic [15:0]        cos_q;
	logic               sugg_q, bypass_q, zder_q;

	// control state
	logic [1:0] slot_q;
	logic       ff_q;
	logic       pass_q;
	logic [1:0] live_q;

	// payload state
	ztc_vtx_t           cur_q;
	ztc_hv_t            hv_q [2];
	logic signed [DW-1:0] d_q;
	logic [LW-1:0]        l_q;
	logic signed [WW-1:0] w_q;
	logic [1:0]         dv_q, s1_q, s2_q;
	logic [32:0]        dr_q;
	logic [32:0]        den_q;
	logic               bring_q;
	logic [QW-1:0]      dq_q;
	logic signed [31:0] seg_q [2][2][3];

	// multiplier pipe
	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] prod_s1;
	logic                 fv_s1, pv_s1;
	logic [STEP_W-1:0]    tstep_s1;
	logic                 tkind_s1, tedge_s1;

	logic signed [31:0] vp [4][3];
	logic signed [31:0] vc [4];
	logic signed [31:0] vd [4];
	logic signed [31:0] cc [4];
	logic               fail;
	logic [2:0]         le0, ge0;
	logic [1:0]         sv;
	logic signed [32:0] cdiff;
	logic [32:0]        den;
	logic [31:0]        acd;
	logic [33:0]        trial;
	logic signed [WW-1:0] pw;
	logic signed [PW-1:0] pt_full;

	assign cfg.ready = 1'b1;

	always_comb begin
		vp[0][0] = hv_q[0].pos_x; vp[0][1] = hv_q[0].pos_y; vp[0][2] = hv_q[0].pos_z;
		vp[1][0] = hv_q[1].pos_x; vp[1][1] = hv_q[1].pos_y; vp[1][2] = hv_q[1].pos_z;
		vp[2][0] = cur_q.pos_x;   vp[2][1] = cur_q.pos_y;   vp[2][2] = cur_q.pos_z;
		vp[3]    = vp[2];
		vc[0] = hv_q[0].curv;  vc[1] = hv_q[1].curv;  vc[2] = cur_q.radial_curv;
		vc[3] = vc[2];
		vd[0] = hv_q[0].deriv; vd[1] = hv_q[1].deriv; vd[2] = cur_q.radial_deriv;
		vd[3] = vd[2];
		for (int i = 0; i < 4; i++) begin
			cc[i] = cmd.kind ? vd[i] : vc[i];
		end
		for (int i = 0; i < 3; i++) begin
			le0[i] = cc[i][31] || (cc[i] == 32'sd0);
			ge0[i] = !cc[i][31];
		end
	end

	// facing: d > 0 and d*d - cos*L*2^12 > 0
	assign fail = !d_q[DW-1] && (d_q != '0) && !w_q[WW-1] && (w_q != '0);

	assign sv    = cmd.edge_sel ? s2_q : s1_q;
	assign cdiff = 33'(cc[dv_q]) - 33'(cc[sv]);
	assign den   = cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
	assign acd   = cc[dv_q][31] ? 32'(-cc[dv_q]) : 32'(cc[dv_q]);
	assign trial = {dr_q, bring_q};

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_FMUL: begin
				case (cmd.step)
					4'd0: begin ma = MW'(cur_q.normal_x); mb = MW'(cur_q.view_x); end
					4'd1: begin ma = MW'(cur_q.normal_y); mb = MW'(cur_q.view_y); end
					4'd2: begin ma = MW'(cur_q.normal_z); mb = MW'(cur_q.view_z); end
					4'd3: begin ma = MW'(cur_q.view_x);   mb = MW'(cur_q.view_x); end
					4'd4: begin ma = MW'(cur_q.view_y);   mb = MW'(cur_q.view_y); end
					4'd5: begin ma = MW'(cur_q.view_z);   mb = MW'(cur_q.view_z); end
					4'd6: begin ma = {9'b0, d_q[23:0]};  mb = {9'b0, d_q[23:0]}; end
					4'd7: begin ma = {9'b0, d_q[47:24]}; mb = {9'b0, d_q[23:0]}; end
					4'd8: begin ma = {9'b0, d_q[47:24]}; mb = {9'b0, d_q[47:24]}; end
					4'd9: begin ma = {17'b0, cos_q};     mb = {1'b0, l_q[31:0]}; end
					4'd10: begin ma = {17'b0, cos_q};    mb = {1'b0, l_q[63:32]}; end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			OP_PMUL: begin
				ma = MW'(vp[dv_q][cmd.step[1:0]]) - MW'(vp[sv][cmd.step[1:0]]);
				mb = MW'(dq_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign pw      = WW'(prod_s1);
	assign pt_full = PW'(vp[dv_q][tstep_s1[1:0]]) - (prod_s1 >>> FRACTION_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= DERIV_THR_RST;
			cos_q    <= COS_SQ_RST;
			sugg_q   <= 1'b1;
			bypass_q <= 1'b0;
			zder_q   <= 1'b0;
			slot_q   <= 2'd0;
			ff_q     <= 1'b0;
			pass_q   <= 1'b0;
			live_q   <= 2'b00;
			fv_s1    <= 1'b0;
			pv_s1    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DERIV_THR: thr_q    <= cfg.data;
					REG_COS_SQ:    cos_q    <= cfg.data[15:0];
					REG_DRAW_SUGG: sugg_q   <= cfg.data[0];
					REG_BYPASS:    bypass_q <= cfg.data[0];
					REG_DRAW_ZDER: zder_q   <= cfg.data[0];
					default: ;
				endcase
			end
			fv_s1 <= (cmd.op == OP_FMUL);
			pv_s1 <= (cmd.op == OP_PMUL);
			if (cmd.op == OP_FDONE) begin
				if (slot_q[1]) begin
					pass_q <= bypass_q ||
						($signed(vd[0]) > thr_q && $signed(vd[1]) > thr_q &&
						 $signed(vd[2]) > thr_q && !(fail || ff_q));
					ff_q   <= 1'b0;
					slot_q <= 2'd0;
				end else begin
					ff_q   <= slot_q[0] ? (ff_q || fail) : fail;
					slot_q <= slot_q + 2'd1;
				end
			end
			if (cmd.op == OP_SEL) begin
				live_q[cmd.kind] <= (cmd.kind ? zder_q : (sugg_q && pass_q)) &&
					((le0[0] && ge0[1] && ge0[2]) || (ge0[0] && le0[1] && le0[2]) ||
					 (le0[1] && ge0[2] && ge0[0]) || (ge0[1] && le0[2] && le0[0]) ||
					 (le0[2] && ge0[0] && ge0[1]) || (ge0[2] && le0[1] && le0[0]));
			end
			if (cmd.op == OP_DINIT && den == '0) begin
				// drop the segment on a zero divisor
				live_q[cmd.kind] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= ma * mb;
		tstep_s1 <= cmd.step;
		tkind_s1 <= cmd.kind;
		tedge_s1 <= cmd.edge_sel;
		if (cmd.op == OP_LOAD) begin
			cur_q <= vtx_data;
		end
		if (cmd.op == OP_FDONE && !slot_q[1]) begin
			hv_q[slot_q[0]] <= '{pos_x: cur_q.pos_x, pos_y: cur_q.pos_y, pos_z: cur_q.pos_z,
				curv: cur_q.radial_curv, deriv: cur_q.radial_deriv};
		end
		if (fv_s1) begin
			case (tstep_s1)
				4'd0: d_q <= prod_s1[DW-1:0];
				4'd1, 4'd2: d_q <= d_q + prod_s1[DW-1:0];
				4'd3: l_q <= prod_s1[LW-1:0];
				4'd4, 4'd5: l_q <= l_q + prod_s1[LW-1:0];
				4'd6: w_q <= pw;
				4'd7: w_q <= w_q + (pw <<< 25);
				4'd8: w_q <= w_q + (pw <<< 48);
				4'd9: w_q <= w_q - (pw <<< 12);
				4'd10: w_q <= w_q - (pw <<< 44);
				default: ;
			endcase
		end
		if (cmd.op == OP_SEL) begin
			if ((le0[0] && ge0[1] && ge0[2]) || (ge0[0] && le0[1] && le0[2])) begin
				dv_q <= 2'd0; s1_q <= 2'd2; s2_q <= 2'd1;
			end else if ((le0[1] && ge0[2] && ge0[0]) || (ge0[1] && le0[2] && le0[0])) begin
				dv_q <= 2'd1; s1_q <= 2'd2; s2_q <= 2'd0;
			end else begin
				dv_q <= 2'd2; s1_q <= 2'd1; s2_q <= 2'd0;
			end
		end
		if (cmd.op == OP_DINIT) begin
			dr_q    <= 33'(acd >> 1);
			bring_q <= acd[0];
			den_q   <= den;
			dq_q    <= '0;
		end
		if (cmd.op == OP_DSTEP) begin
			bring_q <= 1'b0;
			if (trial >= {1'b0, den_q}) begin
				dr_q <= 33'(trial - {1'b0, den_q});
				dq_q <= {dq_q[QW-2:0], 1'b1};
			end else begin
				dr_q <= trial[32:0];
				dq_q <= {dq_q[QW-2:0], 1'b0};
			end
		end
		if (pv_s1) begin
			seg_q[tkind_s1][tedge_s1][tstep_s1[1:0]] <= pt_full[31:0];
		end
	end

	assign sts.third    = slot_q[1];
	assign sts.seg_live = live_q;

	always_comb begin
		seg_data.start_x      = seg_q[cmd.kind][0][0];
		seg_data.start_y      = seg_q[cmd.kind][0][1];
		seg_data.start_z      = seg_q[cmd.kind][0][2];
		seg_data.end_x        = seg_q[cmd.kind][1][0];
		seg_data.end_y        = seg_q[cmd.kind][1][1];
		seg_data.end_z        = seg_q[cmd.kind][1][2];
		seg_data.contour_kind = cmd.kind;
		seg_data.last_of_face = cmd.kind || !live_q[1];
	end
endmodule
`default_nettype wire
